>>> sv/unique_key_stack_unit_defines.svh
// Assertion helpers used by the checker file.
`ifndef UNIQUE_KEY_STACK_UNIT_DEFINES_SVH
`define UNIQUE_KEY_STACK_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define UKS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define UKS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ukstk_pkg.sv
`timescale 1ns / 1ps

package ukstk_pkg;

    // Field widths
    localparam int OP_W        = 2;
    localparam int KEY_W       = 32;
    localparam int DATA_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int CNT_W       = 5;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 136;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd3;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_POP_RD,
        S_DONE
    } t_state;

    // Input tdata layout, last field in the lowest bits
    typedef struct packed {
        logic signed [DATA_W-1:0] data_in;
        logic signed [KEY_W-1:0]  key_in;
    } t_push_data;

    // Output tdata layout, last field in the lowest bits
    typedef struct packed {
        logic [1:0]               pad;
        logic                     is_empty;
        logic [CNT_W-1:0]         entry_count;
        logic signed [DATA_W-1:0] top_data;
        logic signed [KEY_W-1:0]  top_key;
        logic signed [DATA_W-1:0] popped_data;
        logic signed [KEY_W-1:0]  popped_key;
    } t_result;

endpackage

>>> sv/unique_key_stack_unit.sv
// Bounded LIFO stack of key/data pairs with unique keys. Each input transfer
// carries one operation (push, pop, query; code 3 acts as a query) and gives
// exactly one result transfer with the status, the removed pair, the pair now
// on top, the entry count and an empty flag. Entries live in two single-port
// memories with a registered read; the top pair is also kept in registers.
// One item is worked at a time: a query, an underflowing pop, a pop that
// empties the stack or a push onto an empty stack goes straight to the done
// state; any other pop first reads the new top pair, and a push onto a
// nonempty stack first runs the duplicate search, which reads one stored key
// per cycle through the memory read port. A result held in the output
// register while the sink stalls delays only the end of the next item.
// No clearing pass is needed after reset: only entries below the fill count
// are read.
`timescale 1ns / 1ps

module unique_key_stack_unit
    import ukstk_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // key_in, data_in
    input  logic [OP_W-1:0]        i_s_axis_tuser,  // operation
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,  // popped_key, popped_data, top_key,
                                                    // top_data, entry_count, is_empty, pad
    output logic [STATUS_W-1:0]    o_m_axis_tuser   // status
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    // Entry storage
    logic [KEY_W-1:0]  r_key_mem  [STACK_DEPTH];
    logic [DATA_W-1:0] r_data_mem [STACK_DEPTH];

    t_state            r_state, n_state;
    logic [OP_W-1:0]   r_op;
    logic [KEY_W-1:0]  r_key;
    logic [DATA_W-1:0] r_data;
    logic [CW-1:0]     r_fill, n_fill;
    logic [KEY_W-1:0]  r_top_key, n_top_key;
    logic [DATA_W-1:0] r_top_data, n_top_data;
    logic [CW-1:0]     r_rd_idx;
    logic [KEY_W-1:0]  r_rd_key;
    logic [DATA_W-1:0] r_rd_data;
    logic              r_cmp_vld, n_cmp_vld;
    logic              r_dup;
    logic              r_out_valid;
    t_result           r_out_data, n_out_data;
    logic [STATUS_W-1:0] r_out_status, n_out_status;

    logic       in_fire;
    logic       issue;
    logic       hit;
    logic       out_free;
    logic       rd_en;
    logic       done_fire;
    logic       is_push;
    logic       is_pop;
    logic       full;
    logic       push_ok;
    logic       pop_ok;
    logic [CW+CNT_W-1:0] cnt_ext;
    logic [OP_W-1:0]     in_op;
    t_push_data          in_pl;

    assign in_op    = i_s_axis_tuser;
    assign in_pl    = t_push_data'(i_s_axis_tdata);
    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign issue    = (r_rd_idx < r_fill);
    assign hit      = r_cmp_vld && (r_rd_key == r_key);
    assign out_free = !r_out_valid || i_m_axis_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (in_op == OP_PUSH && r_fill != '0) begin
                        n_state = S_SEARCH;
                    end else if (in_op == OP_POP && r_fill > CW'(1)) begin
                        n_state = S_POP_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SEARCH: begin
                if (!issue) begin
                    n_state = S_DONE;
                end
            end
            S_POP_RD: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE);
        rd_en           = (r_state == S_SEARCH && issue) || (r_state == S_POP_RD);
        done_fire       = (r_state == S_DONE) && out_free;
        n_cmp_vld       = (r_state == S_SEARCH) && issue;
    end

    // Outcome of the current operation
    always_comb begin
        is_push = (r_op == OP_PUSH);
        is_pop  = (r_op == OP_POP);
        full    = (r_fill >= DEPTH_C);
        push_ok = is_push && !r_dup && !full;
        pop_ok  = is_pop && (r_fill != '0);

        priority if (is_push && r_dup) begin
            n_out_status = ST_DUP;
        end else if (is_push && full) begin
            n_out_status = ST_OVER;
        end else if (is_pop && r_fill == '0) begin
            n_out_status = ST_UNDER;
        end else begin
            n_out_status = ST_OK;
        end

        n_fill     = r_fill;
        n_top_key  = r_top_key;
        n_top_data = r_top_data;
        if (push_ok) begin
            n_fill     = r_fill + CW'(1);
            n_top_key  = r_key;
            n_top_data = r_data;
        end else if (pop_ok) begin
            n_fill     = r_fill - CW'(1);
            n_top_key  = r_rd_key;
            n_top_data = r_rd_data;
        end

        cnt_ext = {{CNT_W{1'b0}}, n_fill};

        n_out_data             = '0;
        n_out_data.popped_key  = pop_ok ? r_top_key : '0;
        n_out_data.popped_data = pop_ok ? r_top_data : '0;
        n_out_data.top_key     = (n_fill != '0) ? n_top_key : '0;
        n_out_data.top_data    = (n_fill != '0) ? n_top_data : '0;
        n_out_data.entry_count = cnt_ext[CNT_W-1:0];
        n_out_data.is_empty    = (n_fill == '0);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_cmp_vld   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
            if (done_fire) begin
                r_fill <= n_fill;
            end
            if (done_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Operand capture, search index and duplicate flag
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op   <= in_op;
            r_key  <= in_pl.key_in;
            r_data <= in_pl.data_in;
            r_dup  <= 1'b0;
            if (in_op == OP_POP) begin
                r_rd_idx <= r_fill - CW'(2);
            end else begin
                r_rd_idx <= '0;
            end
        end else if (r_state == S_SEARCH) begin
            r_rd_idx <= r_rd_idx + CW'(issue);
            r_dup    <= r_dup | hit;
        end
    end

    // Top pair and result register
    always_ff @(posedge i_clk) begin
        if (done_fire) begin
            r_top_key    <= n_top_key;
            r_top_data   <= n_top_data;
            r_out_data   <= n_out_data;
            r_out_status <= n_out_status;
        end
    end

    // Entry memories: one write on a successful push, one registered read
    always_ff @(posedge i_clk) begin
        if (done_fire && push_ok) begin
            r_key_mem[r_fill[AW-1:0]]  <= r_key;
            r_data_mem[r_fill[AW-1:0]] <= r_data;
        end
        if (rd_en) begin
            r_rd_key  <= r_key_mem[r_rd_idx[AW-1:0]];
            r_rd_data <= r_data_mem[r_rd_idx[AW-1:0]];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_status;

endmodule

>>> sv/ukstk_checker.sv
`timescale 1ns / 1ps
`include "unique_key_stack_unit_defines.svh"

module ukstk_checker
    import ukstk_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] i_m_tdata,
    input logic [STATUS_W-1:0]    i_m_tuser
);

    t_result res;

    assign res = t_result'(i_m_tdata);

    // Empty flag agrees with the count
    `UKS_ASSERT_NOW(a_empty_cnt, i_clk, i_rst_n, i_m_tvalid, res.is_empty == (res.entry_count == '0), "empty flag and count disagree")

    // A refused or failed operation removes nothing
    `UKS_ASSERT_NOW(a_fail_no_pop, i_clk, i_rst_n, i_m_tvalid && i_m_tuser != ST_OK, res.popped_key == '0 && res.popped_data == '0, "popped pair set on failed op")

    // Empty stack shows a zero top pair
    `UKS_ASSERT_NOW(a_empty_top, i_clk, i_rst_n, i_m_tvalid && res.is_empty, res.top_key == '0 && res.top_data == '0, "top pair nonzero on empty stack")

    // Underflow only happens on an empty stack
    `UKS_ASSERT_NOW(a_under_empty, i_clk, i_rst_n, i_m_tvalid && i_m_tuser == ST_UNDER, res.is_empty, "underflow reported on nonempty stack")

    // A stalled result stays offered
    `UKS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid, "result dropped while stalled")

endmodule

bind unique_key_stack_unit ukstk_checker u_ukstk_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser)
);

>>> sim/unique_key_stack_unit_test.sv
`timescale 1ns / 1ps

module unique_key_stack_unit_test;
    import ukstk_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 1120;
    localparam int RUN_LIMIT_NS = 5_000_000;

    // Spare operation code, behaves as a query
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    // Outcome of one stack operation as the block reports it
    typedef struct {
        logic [STATUS_W-1:0] status;
        t_result             res;
    } t_outcome;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;   // key_in, data_in
    logic [OP_W-1:0]        i_s_axis_tuser = '0;   // operation
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;        // popped_key, popped_data, top_key,
                                                   // top_data, entry_count, is_empty, pad
    logic [STATUS_W-1:0]    o_m_axis_tuser;        // status

    // Shadow copy of the stack contents
    logic [KEY_W-1:0]  shadow_keys [DEPTH];
    logic [DATA_W-1:0] shadow_data [DEPTH];
    int unsigned       shadow_level = 0;

    t_outcome pending_outcomes [$];
    int       errors = 0;
    bit       quiet = 1'b0;
    int       rx_wait = 0;

    unique_key_stack_unit #(
        .STACK_DEPTH(DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit key_stored(input logic [KEY_W-1:0] key);
        for (int i = 0; i < shadow_level; i++) begin
            if (shadow_keys[i] == key) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Apply one operation to the shadow stack and return what the block must report
    function automatic t_outcome apply_stack_op(input logic [OP_W-1:0] op,
                                                input logic [KEY_W-1:0] key,
                                                input logic [DATA_W-1:0] data);
        t_outcome o;
        o.status = ST_OK;
        o.res    = '0;
        if (op == OP_PUSH) begin
            // duplicate search wins over the full check
            if (key_stored(key)) begin
                o.status = ST_DUP;
            end else if (shadow_level >= DEPTH) begin
                o.status = ST_OVER;
            end else begin
                shadow_keys[shadow_level] = key;
                shadow_data[shadow_level] = data;
                shadow_level++;
            end
        end else if (op == OP_POP) begin
            if (shadow_level == 0) begin
                o.status = ST_UNDER;
            end else begin
                shadow_level--;
                o.res.popped_key  = shadow_keys[shadow_level];
                o.res.popped_data = shadow_data[shadow_level];
            end
        end
        if (shadow_level > 0) begin
            o.res.top_key  = shadow_keys[shadow_level-1];
            o.res.top_data = shadow_data[shadow_level-1];
        end
        o.res.entry_count = CNT_W'(shadow_level);
        o.res.is_empty    = (shadow_level == 0);
        return o;
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] key;
        do begin
            key = $urandom;
        end while (key_stored(key));
        return key;
    endfunction

    // Key mix for random traffic: stored keys, a small colliding pool, extremes, anything
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20 && shadow_level > 0) begin
            return shadow_keys[$urandom_range(0, shadow_level - 1)];
        end else if (r < 40) begin
            return KEY_W'($signed($urandom_range(0, 15)) - 8);
        end else if (r < 45) begin
            return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        return $urandom;
    endfunction

    // Send one item; returns right after the edge where it was accepted
    task automatic send_op(input logic [OP_W-1:0] op,
                           input logic [KEY_W-1:0] key,
                           input logic [DATA_W-1:0] data);
        int         gap;
        t_push_data payload;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        payload.key_in  = key;
        payload.data_in = data;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= payload;
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_outcomes.push_back(apply_stack_op(op, key, data));
    endtask

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Result checker and sink-side stalls
    always @(posedge i_clk) begin
        t_result  got;
        t_outcome want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata;
            if (pending_outcomes.size() == 0) begin
                $error("result transfer with nothing outstanding");
                errors++;
            end else begin
                want = pending_outcomes.pop_front();
                compare_field("status", want.status, o_m_axis_tuser);
                compare_field("popped_key", want.res.popped_key, got.popped_key);
                compare_field("popped_data", want.res.popped_data, got.popped_data);
                compare_field("top_key", want.res.top_key, got.top_key);
                compare_field("top_data", want.res.top_data, got.top_data);
                compare_field("entry_count", want.res.entry_count, got.entry_count);
                compare_field("is_empty", want.res.is_empty, got.is_empty);
            end
            rx_wait = quiet ? 0 : $urandom_range(0, 4);
        end
        if (rx_wait > 0) begin
            i_m_axis_tready <= 1'b0;
            rx_wait--;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Empty-stack cases, field extremes, duplicates at bottom and top, spare opcode
    task automatic test_corner_cases();
        quiet = 1'b0;
        send_op(OP_QUERY, 32'h0, 32'h0);
        send_op(OP_POP, 32'hffff_ffff, 32'hffff_ffff);
        send_op(OP_SPARE, 32'h1234_5678, 32'h9abc_def0);
        send_op(OP_PUSH, 32'h8000_0000, 32'h7fff_ffff);
        send_op(OP_PUSH, 32'h7fff_ffff, 32'h8000_0000);
        send_op(OP_PUSH, 32'h0, 32'h0);
        send_op(OP_PUSH, 32'hffff_ffff, 32'hffff_ffff);
        send_op(OP_PUSH, 32'h8000_0000, 32'h5555_5555);
        send_op(OP_PUSH, 32'hffff_ffff, 32'haaaa_aaaa);
        send_op(OP_SPARE, 32'haaaa_aaaa, 32'h5555_5555);
        send_op(OP_QUERY, 32'h5555_5555, 32'haaaa_aaaa);
        send_op(OP_POP, 32'h0, 32'h0);
        send_op(OP_POP, 32'h0, 32'h0);
    endtask

    // Fill to the limit back to back, overflow, duplicate on a full stack
    task automatic test_full_stack();
        quiet = 1'b1;
        while (shadow_level < DEPTH) begin
            send_op(OP_PUSH, fresh_key(), $urandom);
        end
        send_op(OP_PUSH, fresh_key(), $urandom);
        send_op(OP_PUSH, shadow_keys[DEPTH-1], $urandom);
        send_op(OP_PUSH, shadow_keys[0], $urandom);
        send_op(OP_POP, $urandom, $urandom);
        send_op(OP_PUSH, fresh_key(), $urandom);
        quiet = 1'b0;
    endtask

    // Bursts biased toward filling, draining or mixing the stack
    task automatic test_random_traffic();
        int              sent;
        int              burst;
        int              push_pct;
        int              pop_pct;
        int              r;
        logic [OP_W-1:0] op;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
                0: begin
                    push_pct = 75;
                    pop_pct  = 15;
                end
                1: begin
                    push_pct = 15;
                    pop_pct  = 75;
                end
                default: begin
                    push_pct = 45;
                    pop_pct  = 45;
                end
            endcase
            quiet = ($urandom_range(0, 3) == 0);
            repeat (burst) begin
                r = $urandom_range(0, 99);
                if (r < push_pct) begin
                    op = OP_PUSH;
                end else if (r < push_pct + pop_pct) begin
                    op = OP_POP;
                end else if (r < push_pct + pop_pct + 7) begin
                    op = OP_QUERY;
                end else begin
                    op = OP_SPARE;
                end
                send_op(op, pick_key(), $urandom);
                sent++;
            end
        end
    endtask

    initial begin
        int waited;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corner_cases();
        test_full_stack();
        test_random_traffic();
        i_s_axis_tvalid <= 1'b0;
        quiet = 1'b0;
        // drain outstanding results, then let the pipeline settle
        waited = 0;
        while (pending_outcomes.size() != 0 && waited < 10000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DEPTH + 8) @(posedge i_clk);
        if (pending_outcomes.size() != 0) begin
            $error("%0d results never arrived", pending_outcomes.size());
            errors++;
        end
        if (errors == 0) begin
            $display("unique_key_stack_unit: match");
        end else begin
            $display("unique_key_stack_unit: mismatch");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(RUN_LIMIT_NS);
        $display("unique_key_stack_unit: mismatch");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/ukstk_pkg.sv
sv/unique_key_stack_unit.sv
sv/ukstk_checker.sv
sim/unique_key_stack_unit_test.sv
